/* design/rv32ex_pkg.sv */
// shared types, codes and constants for the integer execute unit
`default_nettype none
package rv32ex_pkg;

  typedef enum logic [2:0] {
    CMD_REG   = 3'd0,
    CMD_SHIMM = 3'd1,
    CMD_ARIMM = 3'd2,
    CMD_LUI   = 3'd3,
    CMD_AUIPC = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    F3_ADD  = 3'd0,
    F3_SLL  = 3'd1,
    F3_SLT  = 3'd2,
    F3_SLTU = 3'd3,
    F3_XOR  = 3'd4,
    F3_SRL  = 3'd5,
    F3_OR   = 3'd6,
    F3_AND  = 3'd7
  } f3_t;

  localparam logic [6:0] F7_BASE = 7'd0;
  localparam logic [6:0] F7_MEXT = 7'd1;
  localparam logic [6:0] F7_ALT  = 7'd32;

  // operation class decided in the first stage
  typedef enum logic [1:0] {
    CLS_BASE = 2'd0,
    CLS_MUL  = 2'd1,
    CLS_DIV  = 2'd2,
    CLS_ILL  = 2'd3
  } cls_t;

  typedef struct packed {
    logic        valid;
    cls_t        cls;
    logic [2:0]  f3;
    logic [31:0] base_res;
    logic [31:0] a;
    logic [31:0] b;
  } dec_t;

  localparam int DivSteps = 32;

endpackage
`default_nettype wire

/* design/rv32ex_decode.sv */
// decode, legality check and base alu operations
`default_nettype none
module rv32ex_decode (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [2:0]          in_command,
  input  wire logic [2:0]          in_funct3,
  input  wire logic [6:0]          in_funct7,
  input  wire logic [31:0]         in_source_a,
  input  wire logic [31:0]         in_source_b,
  input  wire logic [19:0]         in_immediate,
  input  wire logic [31:0]         in_program_counter,
  output rv32ex_pkg::dec_t         dec_o
);
  import rv32ex_pkg::*;

  dec_t        dec_r, dec_nxt;
  logic [31:0] opb;
  logic        alt;
  logic [4:0]  sh;

  always_comb begin
    dec_nxt       = '0;
    dec_nxt.valid = start;
    dec_nxt.f3    = in_funct3;
    dec_nxt.a     = in_source_a;
    dec_nxt.b     = in_source_b;
    dec_nxt.cls   = CLS_BASE;
    opb = in_source_b;
    alt = 1'b0;
    unique case (in_command)
      CMD_REG: begin
        if (in_funct7 == F7_MEXT)
          dec_nxt.cls = in_funct3[2] ? CLS_DIV : CLS_MUL;
        else if (in_funct7 == F7_BASE) alt = 1'b0;
        else if (in_funct7 == F7_ALT && (in_funct3 == F3_ADD || in_funct3 == F3_SRL))
          alt = 1'b1;
        else dec_nxt.cls = CLS_ILL;
      end
      CMD_SHIMM: begin
        opb = {27'd0, in_immediate[4:0]};
        if (in_funct7 == F7_BASE && (in_funct3 == F3_SLL || in_funct3 == F3_SRL)) alt = 1'b0;
        else if (in_funct7 == F7_ALT && in_funct3 == F3_SRL) alt = 1'b1;
        else dec_nxt.cls = CLS_ILL;
      end
      CMD_ARIMM: begin
        opb = {{20{in_immediate[11]}}, in_immediate[11:0]};
        if (in_funct3 == F3_SLL || in_funct3 == F3_SRL) dec_nxt.cls = CLS_ILL;
      end
      CMD_LUI, CMD_AUIPC: ;
      default: dec_nxt.cls = CLS_ILL;
    endcase
    sh = opb[4:0];
    unique case (in_funct3)
      F3_ADD:  dec_nxt.base_res = alt ? in_source_a - opb : in_source_a + opb;
      F3_SLL:  dec_nxt.base_res = in_source_a << sh;
      F3_SLT:  dec_nxt.base_res = {31'd0, $signed(in_source_a) < $signed(opb)};
      F3_SLTU: dec_nxt.base_res = {31'd0, in_source_a < opb};
      F3_XOR:  dec_nxt.base_res = in_source_a ^ opb;
      F3_SRL:  dec_nxt.base_res = alt ? 32'($signed(in_source_a) >>> sh) : in_source_a >> sh;
      F3_OR:   dec_nxt.base_res = in_source_a | opb;
      F3_AND:  dec_nxt.base_res = in_source_a & opb;
      default: dec_nxt.base_res = '0;
    endcase
    if (in_command == CMD_LUI) dec_nxt.base_res = {in_immediate, 12'd0};
    if (in_command == CMD_AUIPC)
      dec_nxt.base_res = in_program_counter + {in_immediate, 12'd0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) dec_r <= '0;
    else dec_r <= dec_nxt;
  end

  assign dec_o = dec_r;
endmodule
`default_nettype wire

/* design/rv32ex_muldiv.sv */
// pipelined multiplier and radix-2 divider, one quotient bit per stage
`default_nettype none
module rv32ex_muldiv (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  rv32ex_pkg::dec_t dec_i,
  output logic             out_strobe,
  output logic [31:0]      out_result,
  output logic             out_illegal
);
  import rv32ex_pkg::*;

  localparam int N = DivSteps;

  // per-stage state of the divider lane; also carries the other classes
  logic        v_r   [N+1];
  cls_t        cls_r [N+1];
  logic [2:0]  f3_r  [N+1];
  logic [31:0] res_r [N+1];
  logic [31:0] a_r   [N+1];
  logic [31:0] b_r   [N+1];
  logic [31:0] rem_r [N+1];
  logic [31:0] quo_r [N+1];
  logic [31:0] dvs_r [N+1];
  logic        qn_r  [N+1];
  logic        rn_r  [N+1];

  // multiplier partial products (16-bit slices), then sum
  logic [31:0] pll_r, plh_r, phl_r, phh_r;
  logic [63:0] prod, prod_r;

  logic        an, bn;
  logic [31:0] am, bm;
  always_comb begin
    an = dec_i.a[31] & ~dec_i.f3[0];
    bn = dec_i.b[31] & ~dec_i.f3[0];
    am = an ? 32'(-dec_i.a) : dec_i.a;
    bm = bn ? 32'(-dec_i.b) : dec_i.b;
  end

  always_ff @(posedge clk) begin
    v_r[0]   <= rst_n & dec_i.valid;
    cls_r[0] <= dec_i.cls;
    f3_r[0]  <= dec_i.f3;
    res_r[0] <= dec_i.base_res;
    a_r[0]   <= dec_i.a;
    b_r[0]   <= dec_i.b;
    quo_r[0] <= am;
    rem_r[0] <= '0;
    dvs_r[0] <= bm;
    qn_r[0]  <= an ^ bn;
    rn_r[0]  <= an;
    pll_r    <= 32'(dec_i.a[15:0] * dec_i.b[15:0]);
    plh_r    <= 32'(dec_i.a[15:0] * dec_i.b[31:16]);
    phl_r    <= 32'(dec_i.a[31:16] * dec_i.b[15:0]);
    phh_r    <= 32'(dec_i.a[31:16] * dec_i.b[31:16]);
  end

  assign prod = {32'd0, pll_r} + {16'd0, plh_r, 16'd0} + {16'd0, phl_r, 16'd0}
              + {phh_r, 32'd0};

  // full product lines up with stage 1
  always_ff @(posedge clk) begin
    prod_r <= prod;
  end

  // the multiply result is settled into res after stage 1
  logic [31:0] mres;
  always_comb begin
    unique case (f3_r[1][1:0])
      2'd0: mres = prod_r[31:0];
      2'd1: mres = prod_r[63:32] - (a_r[1][31] ? b_r[1] : 32'd0)
                   - (b_r[1][31] ? a_r[1] : 32'd0);
      2'd2: mres = prod_r[63:32] - (a_r[1][31] ? b_r[1] : 32'd0);
      default: mres = prod_r[63:32];
    endcase
  end

  for (genvar s = 0; s < N; s++) begin : g_div
    logic [32:0] trial;
    logic [31:0] rsh;
    always_comb begin
      rsh   = {rem_r[s][30:0], quo_r[s][31]};
      trial = {1'b0, rsh} - {1'b0, dvs_r[s]};
    end
    always_ff @(posedge clk) begin
      v_r[s+1]   <= rst_n & v_r[s];
      cls_r[s+1] <= cls_r[s];
      f3_r[s+1]  <= f3_r[s];
      res_r[s+1] <= (s == 1 && cls_r[s] == CLS_MUL) ? mres : res_r[s];
      a_r[s+1]   <= a_r[s];
      b_r[s+1]   <= b_r[s];
      dvs_r[s+1] <= dvs_r[s];
      qn_r[s+1]  <= qn_r[s];
      rn_r[s+1]  <= rn_r[s];
      if (!trial[32]) begin
        rem_r[s+1] <= trial[31:0];
        quo_r[s+1] <= {quo_r[s][30:0], 1'b1};
      end else begin
        rem_r[s+1] <= rsh;
        quo_r[s+1] <= {quo_r[s][30:0], 1'b0};
      end
    end
  end

  logic        strobe_r, ill_r;
  logic [31:0] out_r, dres;
  logic        bz, ovf;
  always_comb begin
    bz  = (b_r[N] == 32'd0);
    ovf = (a_r[N] == 32'h8000_0000) && (b_r[N] == 32'hffff_ffff) && !f3_r[N][0];
    if (!f3_r[N][1]) begin
      if (bz) dres = 32'hffff_ffff;
      else if (ovf) dres = 32'h8000_0000;
      else dres = qn_r[N] ? 32'(-quo_r[N]) : quo_r[N];
    end else begin
      if (bz) dres = a_r[N];
      else if (ovf) dres = 32'd0;
      else dres = rn_r[N] ? 32'(-rem_r[N]) : rem_r[N];
    end
  end

  always_ff @(posedge clk) begin
    strobe_r <= rst_n & v_r[N];
    ill_r    <= (cls_r[N] == CLS_ILL);
    unique case (cls_r[N])
      CLS_DIV: out_r <= dres;
      CLS_ILL: out_r <= '0;
      default: out_r <= res_r[N];
    endcase
  end

  assign out_strobe  = strobe_r;
  assign out_result  = out_r;
  assign out_illegal = ill_r;
endmodule
`default_nettype wire

/* design/rv32im_integer_execute_unit.sv */
// top level of the rv32im integer execute unit
// Takes one transaction per cycle (busy is always low) and returns each result
// marked by out_strobe for one cycle; results leave in order. The divider sets
// the depth, one quotient bit per pipeline stage; every operation class
// travels the same stages. The receiver cannot stall.
`default_nettype none
module rv32im_integer_execute_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_command,
  input  wire logic [2:0]  in_funct3,
  input  wire logic [6:0]  in_funct7,
  input  wire logic [31:0] in_source_a,
  input  wire logic [31:0] in_source_b,
  input  wire logic [19:0] in_immediate,
  input  wire logic [31:0] in_program_counter,
  output logic             out_strobe,
  output logic [31:0]      out_result,
  output logic             out_illegal
);
  import rv32ex_pkg::*;

  dec_t dec;

  assign busy = 1'b0;

  rv32ex_decode u_decode (
    .clk, .rst_n, .start, .in_command, .in_funct3, .in_funct7, .in_source_a,
    .in_source_b, .in_immediate, .in_program_counter, .dec_o(dec)
  );

  rv32ex_muldiv u_muldiv (
    .clk, .rst_n, .dec_i(dec), .out_strobe, .out_result, .out_illegal
  );
endmodule
`default_nettype wire
